### rtl/bta_pkg.sv
// Shared types and constants of the batched timestamp allocator.
// No dependencies; every other file of the block imports it.
package bta_pkg;

    localparam int STAMP_W = 62;
    localparam int ID_W    = 16;
    localparam int BATCH_W = 21;
    localparam int OPC_W   = 3;
    localparam int KIND_W  = 2;

    // Pending request queue
    localparam int PEND_DEPTH = 16;
    localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);
    localparam int PEND_IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_MIN   = STAMP_W'(1);
    localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(1000);

    localparam logic [OPC_W-1:0] OPC_REQUEST = 3'd0;
    localparam logic [OPC_W-1:0] OPC_APPLIED = 3'd1;
    localparam logic [OPC_W-1:0] OPC_OK      = 3'd2;
    localparam logic [OPC_W-1:0] OPC_FAIL    = 3'd3;
    localparam logic [OPC_W-1:0] OPC_LUP     = 3'd4;
    localparam logic [OPC_W-1:0] OPC_LDOWN   = 3'd5;
    localparam logic [OPC_W-1:0] OPC_RESTORE = 3'd6;

    localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    typedef enum logic [2:0] {
        OP_REQ,
        OP_APPLIED,
        OP_OK,
        OP_FAIL,
        OP_LUP,
        OP_LDOWN,
        OP_RESTORE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_FAIL
    } t_state;

endpackage

### rtl/bta_front.sv
// Front end: accepts input words, decodes the opcode and pushes commands.
// Depends on bta_pkg; feeds bta_cmd_fifo.
module bta_front (
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bta_pkg::OPC_W-1:0]   i_opcode,
    input  logic [bta_pkg::ID_W-1:0]    i_request_id,
    input  logic [bta_pkg::STAMP_W-1:0] i_new_timestamp,
    input  logic                       i_full,
    output logic                       o_push,
    output bta_pkg::t_cmd              o_cmd
);
    import bta_pkg::*;

    logic known;

    always_comb begin
        known        = 1'b1;
        o_cmd.id     = i_request_id;
        o_cmd.value  = i_new_timestamp;
        o_cmd.op     = OP_REQ;
        unique case (i_opcode)
            OPC_REQUEST: o_cmd.op = OP_REQ;
            OPC_APPLIED: o_cmd.op = OP_APPLIED;
            OPC_OK:      o_cmd.op = OP_OK;
            OPC_FAIL:    o_cmd.op = OP_FAIL;
            OPC_LUP:     o_cmd.op = OP_LUP;
            OPC_LDOWN:   o_cmd.op = OP_LDOWN;
            OPC_RESTORE: o_cmd.op = OP_RESTORE;
            default:     known = 1'b0;
        endcase
    end

    assign o_stall = i_full;
    // drop unused opcodes once accepted
    assign o_push  = i_valid && !i_full && known;

endmodule

### rtl/bta_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on bta_pkg.
module bta_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bta_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output bta_pkg::t_cmd o_head
);
    import bta_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push, do_pop;

    assign o_full       = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    assign n_wr_ptr = (r_wr_ptr == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/bta_back.sv
// Back end: stamp counters, pending queue, replay sequencer and result staging.
// Depends on bta_pkg; takes commands from bta_cmd_fifo.
module bta_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [bta_pkg::BATCH_W-1:0]   i_cfg_data,
    input  logic                         i_head_valid,
    input  bta_pkg::t_cmd                i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bta_pkg::KIND_W-1:0]    o_kind,
    output logic [bta_pkg::ID_W-1:0]      o_reply_id,
    output logic [bta_pkg::STAMP_W-1:0]   o_timestamp,
    output logic                         o_last
);
    import bta_pkg::*;

    t_state               r_state, n_state;
    logic [BATCH_W-1:0]    r_batch;
    logic [STAMP_W-1:0]    r_cur, n_cur;
    logic [STAMP_W-1:0]    r_wm, n_wm;
    logic [STAMP_W-1:0]    r_pers, n_pers;
    logic                 r_busy, n_busy;
    logic [ID_W-1:0]       r_q [PEND_DEPTH];
    logic [PEND_CNT_W-1:0] r_pend_cnt, n_pend_cnt;
    logic [PEND_CNT_W-1:0] r_rep_cnt, n_rep_cnt;
    logic [PEND_IDX_W-1:0] r_rep_idx, n_rep_idx;

    // result staging: hold waits until it is known whether it is the last
    logic                 r_hold_valid, r_hold_last;
    t_result              r_hold_res;
    logic                 r_out_valid, r_out_last;
    t_result              r_out_res;

    logic                 can_take, slot_ok, hold_to_out;
    logic                 want_emit, emit, finish, req_done, rep_adv, q_we;
    t_result              res;
    logic                 req_sel, grant_ok, need_commit, pend_full, rep_last;
    logic [ID_W-1:0]       q_rd, req_id;
    logic [STAMP_W:0]      commit_sum, wm_diff;
    logic [STAMP_W-1:0]    commit_target, applied_wm;

    assign can_take    = !r_out_valid || !i_stall;
    assign slot_ok     = !r_hold_valid || can_take;
    assign hold_to_out = r_hold_valid && can_take && (r_hold_last || emit);

    assign q_rd      = r_q[r_rep_idx];
    assign req_sel   = ((r_state == ST_IDLE) && i_head_valid && (i_head.op == OP_REQ))
                       || (r_state == ST_REPLAY);
    assign req_id    = (r_state == ST_REPLAY) ? q_rd : i_head.id;
    assign grant_ok  = (r_cur < r_pers);
    assign need_commit = !r_busy && (!grant_ok || (r_cur >= r_wm));
    assign pend_full = (r_pend_cnt == PEND_CNT_W'(PEND_DEPTH));
    assign rep_last  = ((PEND_CNT_W'(r_rep_idx) + 1'b1) == r_rep_cnt);

    // saturate reservation at the top stamp, watermark at zero
    assign commit_sum    = {1'b0, r_pers} + {{(STAMP_W + 1 - BATCH_W){1'b0}}, r_batch};
    assign commit_target = commit_sum[STAMP_W] ? STAMP_MAX : commit_sum[STAMP_W-1:0];
    assign wm_diff       = {1'b0, i_head.value}
                           - {{(STAMP_W + 2 - BATCH_W){1'b0}}, r_batch[BATCH_W-1:1]};
    assign applied_wm    = wm_diff[STAMP_W] ? '0 : wm_diff[STAMP_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid && (r_pend_cnt != '0)) begin
                    if (i_head.op == OP_OK) begin
                        n_state = ST_REPLAY;
                    end else if (i_head.op == OP_FAIL) begin
                        n_state = ST_FAIL;
                    end
                end
            end
            ST_REPLAY, ST_FAIL: begin
                if (rep_adv && rep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cur      = r_cur;
        n_wm       = r_wm;
        n_pers     = r_pers;
        n_busy     = r_busy;
        n_pend_cnt = r_pend_cnt;
        n_rep_cnt  = r_rep_cnt;
        n_rep_idx  = r_rep_idx;
        want_emit  = 1'b0;
        res        = '0;
        finish     = 1'b0;
        req_done   = 1'b0;
        rep_adv    = 1'b0;
        q_we       = 1'b0;
        o_pop      = 1'b0;

        if (req_sel) begin
            if (need_commit) begin
                want_emit = 1'b1;
                res.kind  = KIND_COMMIT;
                res.stamp = commit_target;
                if (slot_ok) begin
                    n_busy = 1'b1;
                    n_wm   = r_pers;
                end
            end else if (grant_ok) begin
                want_emit = 1'b1;
                res.kind  = KIND_GRANT;
                res.id    = req_id;
                res.stamp = r_cur;
                if (slot_ok) begin
                    n_cur    = r_cur + 1'b1;
                    req_done = 1'b1;
                end
            end else if (!pend_full) begin
                q_we       = 1'b1;
                n_pend_cnt = r_pend_cnt + 1'b1;
                req_done   = 1'b1;
            end else begin
                want_emit = 1'b1;
                res.kind  = KIND_REJECT;
                res.id    = req_id;
                req_done  = slot_ok;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.op) inside
                        OP_REQ: begin
                            o_pop  = req_done;
                            finish = req_done;
                        end
                        OP_APPLIED: begin
                            n_wm   = applied_wm;
                            n_pers = i_head.value;
                            o_pop  = 1'b1;
                            finish = 1'b1;
                        end
                        OP_OK, OP_FAIL: begin
                            // snapshot the queue and empty it
                            n_rep_cnt  = r_pend_cnt;
                            n_rep_idx  = '0;
                            n_pend_cnt = '0;
                            n_busy     = 1'b0;
                            o_pop      = 1'b1;
                            finish     = (r_pend_cnt == '0);
                        end
                        OP_LUP: begin
                            n_cur  = r_pers;
                            n_wm   = r_pers;
                            o_pop  = 1'b1;
                            finish = 1'b1;
                        end
                        OP_LDOWN: begin
                            n_cur  = STAMP_MAX;
                            n_wm   = STAMP_MAX;
                            o_pop  = 1'b1;
                            finish = 1'b1;
                        end
                        OP_RESTORE: begin
                            n_cur  = STAMP_MAX;
                            n_wm   = STAMP_MAX;
                            n_pers = i_head.value;
                            o_pop  = 1'b1;
                            finish = 1'b1;
                        end
                        default: begin
                            o_pop  = 1'b1;
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_REPLAY: begin
                rep_adv = req_done;
                finish  = req_done && rep_last;
            end
            ST_FAIL: begin
                want_emit = 1'b1;
                res.kind  = KIND_ERROR;
                res.id    = q_rd;
                rep_adv   = slot_ok;
                finish    = slot_ok && rep_last;
            end
            default: ;
        endcase

        if (rep_adv) begin
            n_rep_idx = r_rep_idx + 1'b1;
        end
    end

    assign emit = want_emit && slot_ok;

    // re-queued entries land at or below the replay read index
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q[r_pend_cnt[PEND_IDX_W-1:0]] <= req_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hold_res <= res;
        end
        if (hold_to_out) begin
            r_out_res  <= r_hold_res;
            r_out_last <= r_hold_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_batch      <= BATCH_RESET;
            r_cur        <= STAMP_MAX;
            r_wm         <= STAMP_MAX;
            r_pers       <= STAMP_MIN;
            r_busy       <= 1'b0;
            r_pend_cnt   <= '0;
            r_rep_cnt    <= '0;
            r_rep_idx    <= '0;
            r_hold_valid <= 1'b0;
            r_hold_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_wm       <= n_wm;
            r_pers     <= n_pers;
            r_busy     <= n_busy;
            r_pend_cnt <= n_pend_cnt;
            r_rep_cnt  <= n_rep_cnt;
            r_rep_idx  <= n_rep_idx;
            if (i_cfg_valid) begin
                r_batch <= i_cfg_data;
            end

            if (emit) begin
                r_hold_valid <= 1'b1;
                r_hold_last  <= finish;
            end else if (hold_to_out) begin
                r_hold_valid <= 1'b0;
            end else if (finish && r_hold_valid) begin
                r_hold_last <= 1'b1;
            end

            if (hold_to_out) begin
                r_out_valid <= 1'b1;
            end else if (can_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_res.kind;
    assign o_reply_id  = r_out_res.id;
    assign o_timestamp = r_out_res.stamp;
    assign o_last      = r_out_last;

endmodule

### rtl/batched_timestamp_allocator_core.sv
// Batched timestamp allocator: grants strictly increasing stamps below a reserved limit,
// issues reservation commits and replays or fails queued requests on their outcome.
// Depends on bta_pkg, bta_front, bta_cmd_fifo and bta_back.
//
// Input words are decoded and placed in a two-entry command queue, so input is taken
// while the back end works. The back end runs one request step per cycle unless an
// output stall holds it. A request that needs a new reservation first issues the commit,
// and is granted after it only if a stamp is left below the limit; commit ok or fail
// empties the queue, then replays or fails each queued request in order, and the replay
// may start a new commit. Each result passes a hold stage, which decides the last flag
// and lets the result go once that flag is known, and the output register. Up to 17
// results follow one commit ok. The batch size register is written through the
// configuration channel, which is always ready; write it only while the block is idle.
module batched_timestamp_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bta_pkg::BATCH_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bta_pkg::OPC_W-1:0]     i_opcode,
    input  logic [bta_pkg::ID_W-1:0]      i_request_id,
    input  logic [bta_pkg::STAMP_W-1:0]   i_new_timestamp,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bta_pkg::KIND_W-1:0]    o_kind,
    output logic [bta_pkg::ID_W-1:0]      o_reply_id,
    output logic [bta_pkg::STAMP_W-1:0]   o_timestamp,
    output logic                         o_last
);
    import bta_pkg::*;

    logic push, full, pop, head_valid;
    t_cmd cmd, head;

    assign o_cfg_ready = 1'b1;

    bta_front u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_request_id    (i_request_id),
        .i_new_timestamp (i_new_timestamp),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    bta_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    bta_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_reply_id   (o_reply_id),
        .o_timestamp  (o_timestamp),
        .o_last       (o_last)
    );

endmodule

### tb/batched_timestamp_allocator_core_test.sv
// Self-checking testbench for batched_timestamp_allocator_core: directed and random event
// words, an in-bench allocator predictor and an in-order reply check.
// Depends on bta_pkg and the batched_timestamp_allocator_core RTL.
`timescale 1ns / 100ps

module batched_timestamp_allocator_core_test;
    import bta_pkg::*;

    localparam logic [OPC_W-1:0] OPC_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES   = 40;
    localparam int SHOWN_ERRORS   = 10;
    localparam int PHASE_ITEMS    = 32;
    localparam int IDLE_PERCENT   = 24;

    typedef struct {
        logic [OPC_W-1:0]   opcode;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] value;
    } t_event;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_reply;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [BATCH_W-1:0]   i_cfg_data      = '0;
    logic                 i_valid         = 1'b0;
    logic                 o_stall;
    logic [OPC_W-1:0]     i_opcode        = '0;
    logic [ID_W-1:0]      i_request_id    = '0;
    logic [STAMP_W-1:0]   i_new_timestamp = '0;
    logic                 o_valid;
    logic                 i_stall         = 1'b0;
    logic [KIND_W-1:0]    o_kind;
    logic [ID_W-1:0]      o_reply_id;
    logic [STAMP_W-1:0]   o_timestamp;
    logic                 o_last;

    batched_timestamp_allocator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_request_id    (i_request_id),
        .i_new_timestamp (i_new_timestamp),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_reply_id      (o_reply_id),
        .o_timestamp     (o_timestamp),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Allocator shadow state
    logic [BATCH_W-1:0] batch_size_q = BATCH_RESET;
    logic [STAMP_W-1:0] cur_stamp    = STAMP_MAX;
    logic [STAMP_W-1:0] wmark_stamp  = STAMP_MAX;
    logic [STAMP_W-1:0] pers_stamp   = STAMP_MIN;
    logic               commit_busy_q = 1'b0;
    logic [ID_W-1:0]    waiting_ids [PEND_DEPTH] = '{default: '0};
    int                 waiting_cnt = 0;

    t_reply step_replies [$];
    t_reply due_replies [$];
    t_event queued_events [$];
    t_event live_event;
    int     submitted_cnt = 0;
    int     accepted_cnt  = 0;
    int     mismatch_cnt  = 0;
    logic   calm          = 1'b0;
    logic [STAMP_W-1:0] plan_limit = '0;

    function void emit_reply(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [STAMP_W-1:0] stamp);
        t_reply r;
        r.kind  = kind;
        r.id    = id;
        r.stamp = stamp;
        r.last  = 1'b0;
        step_replies = {step_replies, r};
    endfunction

    function void start_reservation();
        logic [STAMP_W:0] target;
        if (!commit_busy_q) begin
            wmark_stamp = pers_stamp;
            target = {1'b0, pers_stamp} + (STAMP_W + 1)'(batch_size_q);
            if (target > {1'b0, STAMP_MAX}) begin
                target = {1'b0, STAMP_MAX};
            end
            emit_reply(KIND_COMMIT, '0, target[STAMP_W-1:0]);
            commit_busy_q = 1'b1;
        end
    endfunction

    function void serve_request(input logic [ID_W-1:0] id);
        logic [STAMP_W-1:0] grant;
        if (cur_stamp < pers_stamp) begin
            grant = cur_stamp;
            cur_stamp = grant + 1'b1;
            if (grant >= wmark_stamp) begin
                start_reservation();
            end
            emit_reply(KIND_GRANT, id, grant);
        end else begin
            start_reservation();
            if (waiting_cnt < PEND_DEPTH) begin
                waiting_ids[waiting_cnt] = id;
                waiting_cnt++;
            end else begin
                emit_reply(KIND_REJECT, id, '0);
            end
        end
    endfunction

    function void compute_replies(input t_event ev);
        logic [ID_W-1:0]    taken [PEND_DEPTH];
        logic [STAMP_W-1:0] half;
        int                 count;
        t_reply             r;
        step_replies.delete();
        case (ev.opcode)
            OPC_REQUEST: serve_request(ev.id);
            OPC_APPLIED: begin
                half = STAMP_W'(batch_size_q >> 1);
                wmark_stamp = (ev.value >= half) ? ev.value - half : '0;
                pers_stamp  = ev.value;
            end
            OPC_OK, OPC_FAIL: begin
                count = waiting_cnt;
                taken = waiting_ids;
                waiting_cnt = 0;
                commit_busy_q = 1'b0;
                for (int i = 0; i < count; i++) begin
                    if (ev.opcode == OPC_OK) begin
                        serve_request(taken[i]);
                    end else begin
                        emit_reply(KIND_ERROR, taken[i], '0);
                    end
                end
            end
            OPC_LUP: begin
                wmark_stamp = pers_stamp;
                cur_stamp   = pers_stamp;
            end
            OPC_LDOWN: begin
                wmark_stamp = STAMP_MAX;
                cur_stamp   = STAMP_MAX;
            end
            OPC_RESTORE: begin
                cur_stamp   = STAMP_MAX;
                wmark_stamp = STAMP_MAX;
                pers_stamp  = ev.value;
            end
            default: ;
        endcase
        if (step_replies.size() != 0) begin
            r = step_replies.pop_back();
            r.last = 1'b1;
            step_replies = {step_replies, r};
        end
        due_replies = {due_replies, step_replies};
    endfunction

    // Event word driver: hold the word while stalled, advance on acceptance
    always @(posedge i_clk) begin : drive_events
        logic idle_now;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                compute_replies(live_event);
                accepted_cnt++;
            end
            if (!i_valid || !o_stall) begin
                idle_now = !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
                if (!idle_now && queued_events.size() != 0) begin
                    live_event = queued_events.pop_front();
                    i_opcode        <= live_event.opcode;
                    i_request_id    <= live_event.id;
                    i_new_timestamp <= live_event.value;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOWN_ERRORS) begin
                        $display("unexpected reply: kind %0d id %h stamp %h last %b",
                                 o_kind, o_reply_id, o_timestamp, o_last);
                    end
                end else begin
                    want = due_replies.pop_front();
                    if (o_kind !== want.kind || o_reply_id !== want.id ||
                        o_timestamp !== want.stamp || o_last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= SHOWN_ERRORS) begin
                            $display("reply mismatch: want kind %0d id %h stamp %h last %b,",
                                     want.kind, want.id, want.stamp, want.last,
                                     " got kind %0d id %h stamp %h last %b",
                                     o_kind, o_reply_id, o_timestamp, o_last);
                        end
                    end
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    function void add_event(input logic [OPC_W-1:0] opcode, input logic [ID_W-1:0] id,
                            input logic [STAMP_W-1:0] value);
        t_event ev;
        ev.opcode = opcode;
        ev.id     = id;
        ev.value  = value;
        queued_events = {queued_events, ev};
        submitted_cnt++;
    endfunction

    function logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom(), $urandom()});
    endfunction

    function logic [ID_W-1:0] rand_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ID_W'($urandom());
        endcase
    endfunction

    // One reservation cycle: optional leader up, requests, applied commit, outcome
    function int add_round(input logic [BATCH_W-1:0] batch);
        int made;
        int reqs;
        made = 0;
        if ($urandom_range(0, 99) < 30) begin
            add_event(OPC_LUP, rand_id(), rand_stamp());
            made++;
        end
        reqs = $urandom_range(0, 20);
        for (int i = 0; i < reqs; i++) begin
            add_event(OPC_REQUEST, rand_id(), rand_stamp());
            made++;
        end
        if ($urandom_range(0, 99) < 85) begin
            plan_limit = (STAMP_MAX - plan_limit < STAMP_W'(batch)) ?
                         STAMP_MAX : plan_limit + STAMP_W'(batch);
        end else begin
            plan_limit = rand_stamp();
        end
        add_event(OPC_APPLIED, rand_id(), plan_limit);
        made++;
        if ($urandom_range(0, 99) < 15) begin
            add_event(OPC_REQUEST, rand_id(), rand_stamp());
            made++;
        end
        add_event(($urandom_range(0, 99) < 80) ? OPC_OK : OPC_FAIL, rand_id(), rand_stamp());
        return made + 1;
    endfunction

    function int add_noise();
        logic [OPC_W-1:0]   opcode;
        logic [STAMP_W-1:0] value;
        opcode = OPC_W'($urandom_range(0, 7));
        value  = ($urandom_range(0, 1) != 0) ? rand_stamp() :
                 plan_limit + STAMP_W'($urandom_range(0, 64));
        if (opcode == OPC_APPLIED || opcode == OPC_RESTORE) begin
            plan_limit = value;
        end
        add_event(opcode, rand_id(), value);
        return (opcode == OPC_UNUSED) ? 0 : 1;
    endfunction

    task automatic wait_idle();
        while (accepted_cnt != submitted_cnt || due_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_batch(input logic [BATCH_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        batch_size_q = value;
    endtask

    initial begin
        logic [BATCH_W-1:0] phase_batch [7];
        int made;
        phase_batch = '{21'd2, 21'd0, 21'd1, 21'd17, 21'd1048576, 21'h1FFFFF, 21'd5};
        phase_batch[6] = BATCH_W'($urandom_range(3, 64));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: queue at reset, fail, fill the queue past full, replay, edge values
        add_event(OPC_REQUEST, 16'h0000, '0);
        add_event(OPC_FAIL, 16'h0000, '0);
        add_event(OPC_LUP, 16'h0000, '0);
        for (int i = 0; i <= PEND_DEPTH; i++) begin
            add_event(OPC_REQUEST, (i == PEND_DEPTH) ? 16'hFFFF : ID_W'(16'h1000 + i), '0);
        end
        add_event(OPC_APPLIED, 16'hFFFF, STAMP_W'(1001));
        add_event(OPC_OK, 16'h0000, '0);
        add_event(OPC_UNUSED, 16'hFFFF, STAMP_MAX);
        // Commit below half a batch: watermark floors at zero
        add_event(OPC_APPLIED, 16'h0000, STAMP_W'(100));
        add_event(OPC_REQUEST, 16'h5A5A, STAMP_MAX);
        add_event(OPC_LDOWN, 16'h0000, '0);
        // Reservation near the top of the range saturates
        add_event(OPC_APPLIED, 16'h0000, STAMP_MAX - 3);
        add_event(OPC_LUP, 16'h0000, '0);
        add_event(OPC_OK, 16'h0000, '0);
        add_event(OPC_REQUEST, 16'hA5A5, '0);
        add_event(OPC_FAIL, 16'h0000, '0);
        add_event(OPC_RESTORE, 16'h0000, '0);
        wait_idle();

        foreach (phase_batch[p]) begin
            write_batch(phase_batch[p]);
            calm = (p == 3);
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 80) begin
                    made += add_round(phase_batch[p]);
                end else begin
                    made += add_noise();
                end
            end
            wait_idle();
            calm = 1'b0;
        end

        if (mismatch_cnt == 0 && due_replies.size() == 0) begin
            $display("batched_timestamp_allocator_core regression: pass");
        end else begin
            $display("batched_timestamp_allocator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("batched_timestamp_allocator_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/bta_pkg.sv
rtl/bta_front.sv
rtl/bta_cmd_fifo.sv
rtl/bta_back.sv
rtl/batched_timestamp_allocator_core.sv
tb/batched_timestamp_allocator_core_test.sv
